@@ rtl/core/doit_pkg.sv @@
// shared types, constants and key compare functions for the interval table
package doit_pkg;

   localparam int DEPTH  = 64;
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int RANK_W = SLOT_W + 1;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_LOOKUP = 2'd2,
      REQ_SPARE  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_DUP      = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_BADRANK  = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] start_pos;
      logic [15:0] end_pos;
      logic        has_end;
      logic [15:0] attr_type;
      logic [15:0] entry_id;
      logic [6:0]  rank_in;
   } req_type_type;

   typedef struct packed {
      logic [2:0] status;
      logic [6:0] start_rank;
      logic [6:0] end_rank;
      logic [6:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] s;
      logic [15:0] e;
      logic [15:0] t;
      logic [15:0] id;
   } key_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_DEL_RD,
      FSM_DEL_KEY,
      FSM_SRCH_RD,
      FSM_SRCH_KEY,
      FSM_SRCH_CMP,
      FSM_CHK_RD,
      FSM_CHK_KEY,
      FSM_DECIDE,
      FSM_SLOT,
      FSM_SHIFT_RD,
      FSM_SHIFT_WR,
      FSM_DONE
   } fsm_type;

   // a strictly before b in the start order
   function automatic logic less_start(key_type a, key_type b);
      logic r;
      if (a.s != b.s) r = a.s < b.s;
      else if (a.e != b.e) r = a.e > b.e;
      else if (a.t != b.t) r = a.t > b.t;
      else r = a.id < b.id;
      return r;
   endfunction

   // a strictly before b in the end order
   function automatic logic less_end(key_type a, key_type b);
      logic r;
      if (a.e != b.e) r = a.e < b.e;
      else if (a.s != b.s) r = a.s > b.s;
      else if (a.t != b.t) r = a.t < b.t;
      else r = a.id > b.id;
      return r;
   endfunction

endpackage

@@ rtl/core/doit_key_store.sv @@
// entry key memory indexed by slot, registered read
module doit_key_store (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [doit_pkg::SLOT_W-1:0] wr_slot,
   input  doit_pkg::key_type          wr_key,
   input  logic [doit_pkg::SLOT_W-1:0] rd_slot,
   output doit_pkg::key_type          rd_key
);
   doit_pkg::key_type mem [doit_pkg::DEPTH];
   doit_pkg::key_type rd_key_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot] <= wr_key;
      end
      rd_key_ff <= mem[rd_slot];
   end

   assign rd_key = rd_key_ff;
endmodule

@@ rtl/core/doit_order_list.sv @@
// one rank list of slot numbers, registered read
module doit_order_list (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [doit_pkg::SLOT_W-1:0] wr_addr,
   input  logic [doit_pkg::SLOT_W-1:0] wr_data,
   input  logic [doit_pkg::SLOT_W-1:0] rd_addr,
   output logic [doit_pkg::SLOT_W-1:0] rd_data
);
   logic [doit_pkg::SLOT_W-1:0] mem [doit_pkg::DEPTH];
   logic [doit_pkg::SLOT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/dual_order_interval_table.sv @@
// top level of the dual-order interval table
//
//  channel | ports                       | transfer
//  --------+-----------------------------+------------------------------
//  request | start, busy, req_payload    | start high while busy low
//  result  | rsp_valid, rsp_payload      | rsp_valid high, one cycle
//
// search: one shared comparator runs a binary search over an order list; each
//   probe reads a slot, fetches its key and compares, and a final step closes it
// lookup: searches both lists, then checks the start-order entry for a match; an
//   insert adds a slot step and shifts both lists, each entry read, then written
// delete: reads its entry key through DEL_RD and DEL_KEY, runs one end-order
//   search, then shifts both lists and gives the result; a bad rank goes to the result
// reset clears the count, the free map and the sequencer; memories keep contents
// the receiver cannot stall: the result strobe lasts one cycle, busy drops after it
module dual_order_interval_table (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  doit_pkg::req_type_type req_payload,
   output logic                   rsp_valid,
   output doit_pkg::rsp_type      rsp_payload
);
   localparam int SW = doit_pkg::SLOT_W;
   localparam int RW = doit_pkg::RANK_W;

   doit_pkg::fsm_type state_ff, state_in;

   // request capture
   doit_pkg::req_type_type req_ff, req_in;
   doit_pkg::key_type      key_ff, key_in;

   // search bounds and results
   logic [RW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic          which_ff, which_in;   // 0 start order, 1 end order
   logic [RW-1:0] sr_ff, sr_in, er_ff, er_in;
   logic [RW-1:0] cnt_ff, cnt_in;
   logic [doit_pkg::DEPTH-1:0] free_ff, free_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic          found_now;
   logic [2:0]    status_ff, status_in;

   // shift pass: idx walks the list, phase picks the list
   logic [RW-1:0] idx_ff, idx_in;
   logic          phase_ff, phase_in;
   logic          ins_ff, ins_in;       // 1 insert shift, 0 delete shift

   // memory ports
   logic          kw_en;
   logic [SW-1:0] k_rd_slot;
   doit_pkg::key_type k_rd;
   logic          sw_en, ew_en;
   logic [SW-1:0] l_wr_addr, l_wr_data, l_rd_addr;
   logic [SW-1:0] s_rd, e_rd;
   logic [RW-1:0] mid;
   logic          lt;

   doit_key_store u_keys (
      .clock(clock), .wr_en(kw_en), .wr_slot(slot_ff), .wr_key(key_ff),
      .rd_slot(k_rd_slot), .rd_key(k_rd)
   );
   doit_order_list u_start (
      .clock(clock), .wr_en(sw_en), .wr_addr(l_wr_addr), .wr_data(l_wr_data),
      .rd_addr(l_rd_addr), .rd_data(s_rd)
   );
   doit_order_list u_end (
      .clock(clock), .wr_en(ew_en), .wr_addr(l_wr_addr), .wr_data(l_wr_data),
      .rd_addr(l_rd_addr), .rd_data(e_rd)
   );

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   // slot read from the list that the current pass uses
   logic [SW-1:0] list_rd;
   assign list_rd = which_ff ? e_rd : s_rd;
   // key fetch for delete and the found check always comes from the start order
   assign k_rd_slot = (state_ff == doit_pkg::FSM_DEL_KEY || state_ff == doit_pkg::FSM_CHK_KEY)
                      ? s_rd : list_rd;
   // the shared comparator
   assign lt = which_ff ? doit_pkg::less_end(k_rd, key_ff)
                        : doit_pkg::less_start(k_rd, key_ff);
   // key of the entry at the start-order insertion point, valid in DECIDE
   assign found_now = (sr_ff < cnt_ff) && (k_rd == key_ff);

   // lowest free slot
   logic [SW-1:0] free_slot;
   always_comb begin
      free_slot = '0;
      for (int i = doit_pkg::DEPTH - 1; i >= 0; i--) begin
         if (free_ff[i]) free_slot = SW'(i);
      end
   end

   // list read address
   always_comb begin
      l_rd_addr = mid[SW-1:0];
      unique case (state_ff)
         doit_pkg::FSM_DEL_RD:   l_rd_addr = req_ff.rank_in[SW-1:0];
         doit_pkg::FSM_CHK_RD:   l_rd_addr = sr_ff[SW-1:0];
         doit_pkg::FSM_SHIFT_RD: begin
            if (ins_ff) l_rd_addr = SW'(idx_ff - RW'(1));
            else        l_rd_addr = SW'(idx_ff + RW'(1));
         end
         default:                l_rd_addr = mid[SW-1:0];
      endcase
   end

   // list writes during the shift pass
   logic [RW-1:0] pos;
   assign pos = phase_ff ? er_ff : sr_ff;
   logic shift_last;
   always_comb begin
      sw_en = 1'b0;
      ew_en = 1'b0;
      l_wr_addr = idx_ff[SW-1:0];
      l_wr_data = phase_ff ? e_rd : s_rd;
      if (state_ff == doit_pkg::FSM_SHIFT_WR) begin
         if (ins_ff && idx_ff == pos) l_wr_data = slot_ff;
         sw_en = !phase_ff;
         ew_en = phase_ff;
      end
   end
   assign kw_en = (state_ff == doit_pkg::FSM_SLOT);
   // insert walks down from cnt to pos, delete walks up from pos to cnt-2
   assign shift_last = ins_ff ? (idx_ff == pos) : (idx_ff + RW'(2) >= cnt_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         doit_pkg::FSM_IDLE:
            if (start) begin
               if (req_payload.req_type == doit_pkg::REQ_DELETE) begin
                  if (RW'(req_payload.rank_in) >= cnt_ff) state_in = doit_pkg::FSM_DONE;
                  else state_in = doit_pkg::FSM_DEL_RD;
               end else begin
                  state_in = doit_pkg::FSM_SRCH_RD;
               end
            end
         doit_pkg::FSM_DEL_RD:   state_in = doit_pkg::FSM_DEL_KEY;
         doit_pkg::FSM_DEL_KEY:  state_in = doit_pkg::FSM_SRCH_RD;
         doit_pkg::FSM_SRCH_RD:
            if (lo_ff >= hi_ff) begin
               if (which_ff) begin
                  state_in = (req_ff.req_type == doit_pkg::REQ_DELETE)
                             ? doit_pkg::FSM_SHIFT_RD : doit_pkg::FSM_CHK_RD;
               end else begin
                  state_in = doit_pkg::FSM_SRCH_RD;
               end
            end else begin
               state_in = doit_pkg::FSM_SRCH_KEY;
            end
         doit_pkg::FSM_SRCH_KEY: state_in = doit_pkg::FSM_SRCH_CMP;
         doit_pkg::FSM_SRCH_CMP: state_in = doit_pkg::FSM_SRCH_RD;
         doit_pkg::FSM_CHK_RD:   state_in = doit_pkg::FSM_CHK_KEY;
         doit_pkg::FSM_CHK_KEY:  state_in = doit_pkg::FSM_DECIDE;
         doit_pkg::FSM_DECIDE:
            if (req_ff.req_type == doit_pkg::REQ_INSERT && !found_now
                && cnt_ff < RW'(doit_pkg::DEPTH))
               state_in = doit_pkg::FSM_SLOT;
            else
               state_in = doit_pkg::FSM_DONE;
         doit_pkg::FSM_SLOT:     state_in = doit_pkg::FSM_SHIFT_RD;
         doit_pkg::FSM_SHIFT_RD: state_in = doit_pkg::FSM_SHIFT_WR;
         doit_pkg::FSM_SHIFT_WR:
            if (shift_last && phase_ff) state_in = doit_pkg::FSM_DONE;
            else state_in = doit_pkg::FSM_SHIFT_RD;
         doit_pkg::FSM_DONE:     state_in = doit_pkg::FSM_IDLE;
         default:                state_in = doit_pkg::FSM_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      req_in = req_ff;
      key_in = key_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      which_in = which_ff;
      sr_in = sr_ff;
      er_in = er_ff;
      cnt_in = cnt_ff;
      free_in = free_ff;
      slot_in = slot_ff;
      status_in = status_ff;
      idx_in = idx_ff;
      phase_in = phase_ff;
      ins_in = ins_ff;
      unique case (state_ff)
         doit_pkg::FSM_IDLE:
            if (start) begin
               req_in = req_payload;
               key_in.s = req_payload.start_pos;
               key_in.e = req_payload.has_end ? req_payload.end_pos : req_payload.start_pos;
               key_in.t = req_payload.attr_type;
               key_in.id = req_payload.entry_id;
               lo_in = '0;
               hi_in = cnt_ff;
               status_in = doit_pkg::ST_OK;
               sr_in = RW'(req_payload.rank_in);
               er_in = '0;
               if (req_payload.req_type == doit_pkg::REQ_DELETE) begin
                  which_in = 1'b1;
                  if (RW'(req_payload.rank_in) >= cnt_ff) status_in = doit_pkg::ST_BADRANK;
               end else begin
                  which_in = 1'b0;
               end
            end
         doit_pkg::FSM_DEL_RD: ;
         doit_pkg::FSM_DEL_KEY: begin
            // s_rd holds the slot; its key is fetched this cycle
            slot_in = s_rd;
         end
         doit_pkg::FSM_SRCH_RD: begin
            if (lo_ff >= hi_ff) begin
               if (!which_ff) begin
                  sr_in = lo_ff;
                  which_in = 1'b1;
                  lo_in = '0;
                  hi_in = cnt_ff;
               end else begin
                  er_in = lo_ff;
                  if (req_ff.req_type == doit_pkg::REQ_DELETE) begin
                     if (lo_ff >= cnt_ff) er_in = cnt_ff - RW'(1);
                     // delete shift starts with the start list at rank_in
                     ins_in = 1'b0;
                     phase_in = 1'b0;
                     idx_in = RW'(req_ff.rank_in);
                     free_in[slot_ff] = 1'b1;
                  end
               end
            end
         end
         doit_pkg::FSM_SRCH_KEY: ;
         doit_pkg::FSM_SRCH_CMP: begin
            if (lt) lo_in = mid + RW'(1);
            else    hi_in = mid;
         end
         doit_pkg::FSM_CHK_RD: ;
         doit_pkg::FSM_CHK_KEY: ;
         doit_pkg::FSM_DECIDE: begin
            if (found_now) begin
               status_in = (req_ff.req_type == doit_pkg::REQ_INSERT)
                           ? doit_pkg::ST_DUP : doit_pkg::ST_OK;
            end else if (req_ff.req_type != doit_pkg::REQ_INSERT) begin
               status_in = doit_pkg::ST_NOTFOUND;
            end else if (cnt_ff >= RW'(doit_pkg::DEPTH)) begin
               status_in = doit_pkg::ST_FULL;
            end else begin
               slot_in = free_slot;
               ins_in = 1'b1;
               phase_in = 1'b0;
               idx_in = cnt_ff;
            end
         end
         doit_pkg::FSM_SLOT: begin
            free_in[slot_ff] = 1'b0;
         end
         doit_pkg::FSM_SHIFT_RD: ;
         doit_pkg::FSM_SHIFT_WR: begin
            if (shift_last) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  idx_in = ins_ff ? cnt_ff : er_ff;
               end else begin
                  cnt_in = ins_ff ? cnt_ff + RW'(1) : cnt_ff - RW'(1);
               end
            end else begin
               idx_in = ins_ff ? idx_ff - RW'(1) : idx_ff + RW'(1);
            end
         end
         doit_pkg::FSM_DONE: ;
         default: ;
      endcase
   end

   // delete: the key of the entry becomes the search key once read
   logic del_key_pending_ff, del_key_pending_in;
   always_comb begin
      del_key_pending_in = (state_ff == doit_pkg::FSM_DEL_KEY);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= doit_pkg::FSM_IDLE;
         cnt_ff   <= '0;
         free_ff  <= '1;
         del_key_pending_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         free_ff  <= free_in;
         del_key_pending_ff <= del_key_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      // in the cycle after DEL_KEY k_rd holds the key of the slot to delete
      key_ff <= del_key_pending_ff ? k_rd : key_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      which_ff <= which_in;
      sr_ff <= sr_in;
      er_ff <= er_in;
      slot_ff <= slot_in;
      status_ff <= status_in;
      idx_ff <= idx_in;
      phase_ff <= phase_in;
      ins_ff <= ins_in;
   end

   assign busy = (state_ff != doit_pkg::FSM_IDLE);
   assign rsp_valid = (state_ff == doit_pkg::FSM_DONE);
   assign rsp_payload.status      = status_ff;
   assign rsp_payload.start_rank  = 7'(sr_ff);
   assign rsp_payload.end_rank    = 7'(er_ff);
   assign rsp_payload.entry_count = 7'(cnt_ff);
endmodule

@@ rtl/core/doit_checker.sv @@
// port-level checks for the interval table, bound to the top level
module doit_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input doit_pkg::rsp_type      rsp_payload
);
   // a transfer in makes the block busy next cycle
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");
   // one result per request: strobe is a single pulse
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("strobe longer than one cycle");
   // busy drops right after the result
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after result");
   // status codes stay in range
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status <= doit_pkg::ST_BADRANK)
      else $error("bad status");
   // count never exceeds depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.entry_count <= 7'(doit_pkg::DEPTH))
      else $error("count overflow");
endmodule

bind dual_order_interval_table doit_checker u_doit_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_payload(rsp_payload)
);

@@ tb/sv/tb_dual_order_interval_table.sv @@
// testbench for the dual-order interval table: directed and random requests checked against a predictor
`timescale 1ns / 1ps

// scoreboard: predicts each result from its own copy of the table and checks strobed results
class interval_table_scoreboard;
   doit_pkg::key_type table_keys[$];   // keys in start order
   doit_pkg::key_type end_list[$];     // keys in end order
   doit_pkg::rsp_type pending_rsp[$];
   int         mismatch_count;
   int         result_count;
   int         status_seen[5];

   function bit start_less(doit_pkg::key_type a, doit_pkg::key_type b);
      if (a.s != b.s) return a.s < b.s;
      if (a.e != b.e) return a.e > b.e;
      if (a.t != b.t) return a.t > b.t;
      return a.id < b.id;
   endfunction

   function bit end_less(doit_pkg::key_type a, doit_pkg::key_type b);
      if (a.e != b.e) return a.e < b.e;
      if (a.s != b.s) return a.s > b.s;
      if (a.t != b.t) return a.t < b.t;
      return a.id > b.id;
   endfunction

   function int bound_in(ref doit_pkg::key_type lst[$], input doit_pkg::key_type k,
                         input bit by_end);
      int pos;
      pos = 0;
      while (pos < lst.size() && (by_end ? end_less(lst[pos], k) : start_less(lst[pos], k)))
         pos++;
      return pos;
   endfunction

   // note an accepted request and queue its expected result
   function void note_request(doit_pkg::req_type_type rq);
      doit_pkg::key_type k;
      doit_pkg::rsp_type r;
      int      sr, er;
      r = '0;
      k.s = rq.start_pos;
      k.e = rq.has_end ? rq.end_pos : rq.start_pos;
      k.t = rq.attr_type;
      k.id = rq.entry_id;
      if (rq.req_type == doit_pkg::REQ_DELETE) begin
         if (rq.rank_in >= table_keys.size()) begin
            r.status = doit_pkg::ST_BADRANK;
            r.start_rank = rq.rank_in;
            r.end_rank = '0;
         end else begin
            k = table_keys[rq.rank_in];
            er = bound_in(end_list, k, 1'b1);
            table_keys.delete(rq.rank_in);
            end_list.delete(er);
            r.status = doit_pkg::ST_OK;
            r.start_rank = rq.rank_in;
            r.end_rank = 7'(er);
         end
      end else begin
         sr = bound_in(table_keys, k, 1'b0);
         er = bound_in(end_list, k, 1'b1);
         r.start_rank = 7'(sr);
         r.end_rank = 7'(er);
         if (sr < table_keys.size() && table_keys[sr] == k)
            r.status = (rq.req_type == doit_pkg::REQ_INSERT) ? doit_pkg::ST_DUP
                                                              : doit_pkg::ST_OK;
         else if (rq.req_type != doit_pkg::REQ_INSERT)
            r.status = doit_pkg::ST_NOTFOUND;
         else if (table_keys.size() >= doit_pkg::DEPTH)
            r.status = doit_pkg::ST_FULL;
         else begin
            r.status = doit_pkg::ST_OK;
            table_keys.insert(sr, k);
            end_list.insert(er, k);
         end
      end
      r.entry_count = 7'(table_keys.size());
      pending_rsp.push_back(r);
   endfunction

   // compare a strobed result with the oldest expectation
   function void check_result(doit_pkg::rsp_type got);
      doit_pkg::rsp_type want;
      result_count++;
      if (pending_rsp.size() == 0) begin
         report("unexpected result", got, '0);
         return;
      end
      want = pending_rsp.pop_front();
      if (want.status < 5) status_seen[want.status]++;
      if (got.status != want.status) report("status", got, want);
      if (got.start_rank != want.start_rank) report("start_rank", got, want);
      if (got.end_rank != want.end_rank) report("end_rank", got, want);
      if (got.entry_count != want.entry_count) report("entry_count", got, want);
   endfunction

   function void report(string what, doit_pkg::rsp_type got, doit_pkg::rsp_type want);
      mismatch_count++;
      $display("mismatch %s at result %0d: got %h want %h", what, result_count, got, want);
   endfunction
endclass

module tb_dual_order_interval_table;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   doit_pkg::req_type_type req_payload;
   logic                   rsp_valid;
   doit_pkg::rsp_type      rsp_payload;

   interval_table_scoreboard board;
   int unsigned   cycle_count;
   int unsigned   request_count;
   doit_pkg::key_type recent_keys[$];   // keys of the last 200 insert requests, reused for hits and duplicates

   localparam int unsigned CYCLE_LIMIT = 4_000_000;

   dual_order_interval_table i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // result side: the strobe lasts one cycle, sample it at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_result(rsp_payload);
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL dual_order_interval_table");
         $finish;
      end
   end

   // random gap before a request: mostly none or short, now and then long
   task automatic idle_gap();
      int unsigned n, pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) n = 0;
      else if (pick < 92) n = $urandom_range(1, 4);
      else n = $urandom_range(10, 60);
      repeat (n) @(negedge clock);
   endtask

   // one transfer on the request channel; start held until busy is low at an edge
   task automatic send_request(doit_pkg::req_type_type rq);
      bit taken;
      req_payload = rq;
      start = 1'b1;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
      end
      board.note_request(rq);
      request_count++;
      if (rq.req_type == doit_pkg::REQ_INSERT)
         recent_keys.push_back({rq.start_pos, rq.has_end ? rq.end_pos : rq.start_pos,
                                rq.attr_type, rq.entry_id});
      if (recent_keys.size() > 200) void'(recent_keys.pop_front());
      @(negedge clock);
      start = 1'b0;
   endtask

   function automatic doit_pkg::req_type_type make_req(doit_pkg::req_kind_type kind,
                                              logic [15:0] s,
                                              logic [15:0] e, logic he, logic [15:0] t,
                                              logic [15:0] id, logic [6:0] rank);
      doit_pkg::req_type_type rq;
      rq.req_type = kind;
      rq.start_pos = s;
      rq.end_pos = e;
      rq.has_end = he;
      rq.attr_type = t;
      rq.entry_id = id;
      rq.rank_in = rank;
      return rq;
   endfunction

   // random request; small value ranges give ties, duplicates and hits
   function automatic doit_pkg::req_type_type random_req(int fill_bias);
      doit_pkg::req_type_type rq;
      doit_pkg::key_type      k;
      int unsigned  pick;
      rq = '0;
      rq.start_pos = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
      rq.end_pos = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
      rq.has_end = 1'($urandom_range(0, 1));
      rq.attr_type = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      rq.entry_id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
      rq.rank_in = 7'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < fill_bias) rq.req_type = doit_pkg::REQ_INSERT;
      else if (pick < fill_bias + 25) rq.req_type = doit_pkg::REQ_DELETE;
      else if (pick < 96) rq.req_type = doit_pkg::REQ_LOOKUP;
      else rq.req_type = doit_pkg::REQ_SPARE;
      if (rq.req_type == doit_pkg::REQ_DELETE)
         rq.rank_in = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                    : 7'($urandom_range(0, board.table_keys.size() + 1));
      // reuse a stored key for hits and duplicates
      if (rq.req_type != doit_pkg::REQ_DELETE && recent_keys.size() > 0
          && $urandom_range(0, 2) == 0) begin
         k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
         rq.start_pos = k.s;
         rq.attr_type = k.t;
         rq.entry_id = k.id;
         rq.has_end = (k.e != k.s) ? 1'b1 : rq.has_end;
         rq.end_pos = rq.has_end ? k.e : rq.end_pos;
      end
      return rq;
   endfunction

   initial begin
      int i, phase;
      board = new();
      request_count = 0;
      start = 1'b0;
      req_payload = '0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty table cases
      send_request(make_req(doit_pkg::REQ_DELETE, 0, 0, 0, 0, 0, 0));
      send_request(make_req(doit_pkg::REQ_DELETE, 0, 0, 0, 0, 0, 7'h7F));
      send_request(make_req(doit_pkg::REQ_LOOKUP, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF,
                            16'hFFFF, 0));
      // extremes and ties on every key field
      send_request(make_req(doit_pkg::REQ_INSERT, 0, 0, 0, 0, 0, 0));
      send_request(make_req(doit_pkg::REQ_INSERT, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF,
                            16'hFFFF, 0));
      send_request(make_req(doit_pkg::REQ_INSERT, 5, 9, 1, 2, 3, 0));
      send_request(make_req(doit_pkg::REQ_INSERT, 5, 9, 1, 2, 4, 0));
      send_request(make_req(doit_pkg::REQ_INSERT, 5, 9, 1, 7, 3, 0));
      send_request(make_req(doit_pkg::REQ_INSERT, 5, 12, 1, 2, 3, 0));
      send_request(make_req(doit_pkg::REQ_INSERT, 3, 9, 1, 2, 3, 0));
      // missing end ignores end_pos: equal to start-only key, a duplicate
      send_request(make_req(doit_pkg::REQ_INSERT, 7, 0, 0, 1, 1, 0));
      send_request(make_req(doit_pkg::REQ_INSERT, 7, 16'hABCD, 0, 1, 1, 0));
      send_request(make_req(doit_pkg::REQ_INSERT, 7, 7, 1, 1, 1, 0));
      send_request(make_req(doit_pkg::REQ_LOOKUP, 5, 9, 1, 2, 4, 0));
      send_request(make_req(doit_pkg::REQ_LOOKUP, 5, 9, 1, 2, 5, 0));
      send_request(make_req(doit_pkg::REQ_SPARE, 5, 9, 1, 7, 3, 0));
      send_request(make_req(doit_pkg::REQ_SPARE, 6, 9, 1, 7, 3, 0));
      send_request(make_req(doit_pkg::REQ_DELETE, 0, 0, 0, 0, 0, 2));
      send_request(make_req(doit_pkg::REQ_DELETE, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF,
                            16'hFFFF, 0));
      send_request(make_req(doit_pkg::REQ_DELETE, 0, 0, 0, 0, 0, 64));
      // fill to full and beyond, then drain by last rank
      for (i = 0; i < 66; i++)
         send_request(make_req(doit_pkg::REQ_INSERT, 16'($urandom), 16'($urandom),
                               1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 0));
      send_request(make_req(doit_pkg::REQ_LOOKUP, 16'h1234, 1, 1, 2, 3, 0));
      send_request(make_req(doit_pkg::REQ_DELETE, 0, 0, 0, 0, 0, 64));
      send_request(make_req(doit_pkg::REQ_DELETE, 0, 0, 0, 0, 0, 63));
      while (board.table_keys.size() > 0)
         send_request(make_req(doit_pkg::REQ_DELETE, 0, 0, 0, 0, 0,
                               7'(board.table_keys.size() - 1)));

      // random phases: filling, churn near full, draining
      for (phase = 0; phase < 6; phase++) begin
         for (i = 0; i < 250; i++) begin
            idle_gap();
            send_request(random_req(phase % 3 == 0 ? 70 : (phase % 3 == 1 ? 40 : 10)));
         end
      end

      // drain and let the last request finish
      while (board.pending_rsp.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("%0d requests sent, %0d results checked", request_count, board.result_count);
      $display("statuses: ok %0d, full %0d, duplicate %0d, not found %0d, bad rank %0d",
               board.status_seen[0], board.status_seen[1], board.status_seen[2],
               board.status_seen[3], board.status_seen[4]);
      if (board.mismatch_count == 0 && board.pending_rsp.size() == 0)
         $display("PASS dual_order_interval_table");
      else
         $display("FAIL dual_order_interval_table");
      $finish;
   end

endmodule
